### rtl/core/assert_macros.svh
// Assertion macros shared by the charge arbiter RTL.
// No dependencies; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every rising clock edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_SYNC(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/core/dica_pkg.sv
// Types, codes and reset constants for the dual-input charge arbiter.
// No dependencies; imported by every module of the block.
package dica_pkg;

   localparam int CUR_W     = 12;
   localparam int CSR_IDX_W = 1;

   // Event kinds carried in req_tuser
   typedef enum logic [1:0] {
      ACT_VBUS  = 2'd0,
      ACT_OTG   = 2'd1,
      ACT_TCOTG = 2'd2,
      ACT_ROUTE = 2'd3
   } action_type;

   // Trigger sources of a vbus sample; the spare code is always ignored
   localparam logic [1:0] SRC_MAG   = 2'd0;
   localparam logic [1:0] SRC_TYPEC = 2'd1;
   localparam logic [1:0] SRC_TIMER = 2'd2;
   localparam logic [1:0] SRC_NONE  = 2'd3;

   // Mode codes
   localparam logic [2:0] MODE_IDLE     = 3'd0;
   localparam logic [2:0] MODE_EXT_OTG  = 3'd1;
   localparam logic [2:0] MODE_TC_OTG   = 3'd2;
   localparam logic [2:0] MODE_MAG_CHG  = 3'd3;
   localparam logic [2:0] MODE_TC_CHG   = 3'd4;
   localparam logic [2:0] MODE_BOTH_CHG = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_CURRENT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_CURRENT = 1'd1;

   localparam logic [CUR_W-1:0] NORMAL_CURRENT_RST = 12'd2000;
   localparam logic [CUR_W-1:0] DOUBLE_CURRENT_RST = 12'd500;

   typedef struct packed {
      logic [CUR_W-1:0] normal_current_ma;
      logic [CUR_W-1:0] double_input_current_ma;
   } cfg_type;

   typedef struct packed {
      action_type action;
      logic [1:0] trigger_source;
      logic       mag_vbus;
      logic       typec_vbus;
      logic       otg_id_high;
      logic       host_otg_present;
      logic       enable;
   } item_type;

   typedef struct packed {
      logic [2:0]       mode;
      logic             data_switch;
      logic             boost_write;
      logic             boost_on;
      logic             current_write;
      logic [CUR_W-1:0] current_limit_ma;
      logic             force_recharge;
      logic             rerun_detect;
      logic             recheck_otg;
      logic             notify;
      logic             refused;
   } result_type;

   typedef struct packed {
      logic mag_input_valid;
      logic typec_input_valid;
      logic ext_otg_active;
      logic typec_otg_active;
      logic mag_data_routed;
      logic ext_otg_seen;
      logic mag_event_enabled;
      logic typec_event_enabled;
      logic data_switch_level;
   } state_type;

   localparam state_type STATE_RST = '{
      mag_input_valid:     1'b0,
      typec_input_valid:   1'b0,
      ext_otg_active:      1'b0,
      typec_otg_active:    1'b0,
      mag_data_routed:     1'b0,
      ext_otg_seen:        1'b0,
      mag_event_enabled:   1'b1,
      typec_event_enabled: 1'b1,
      data_switch_level:   1'b0
   };

endpackage

### rtl/core/dica_csr_regs.sv
// Current limit registers of the charge arbiter.
// Depends on dica_pkg.
module dica_csr_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dica_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dica_pkg::CUR_W-1:0]          csr_data,
   output dica_pkg::cfg_type                   cfg
);
   import dica_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NORMAL_CURRENT: cfg_in.normal_current_ma       = csr_data;
            CSR_DOUBLE_CURRENT: cfg_in.double_input_current_ma = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal_current_ma       <= NORMAL_CURRENT_RST;
         cfg_ff.double_input_current_ma <= DOUBLE_CURRENT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/dica_arb_step.sv
// Event evaluation of the charge arbiter: next state and result for one beat.
// Depends on dica_pkg; purely combinational.
module dica_arb_step (
   input  dica_pkg::state_type  st_cur,
   input  dica_pkg::item_type   item,
   input  dica_pkg::cfg_type    cfg,
   output dica_pkg::state_type  st_next,
   output dica_pkg::result_type res
);
   import dica_pkg::*;

   always_comb begin
      logic take;
      logic ext_a;
      logic tc_a;
      logic redetect_due;
      logic host;

      st_next      = st_cur;
      res          = '0;
      take         = 1'b0;
      ext_a        = item.mag_vbus & ~st_cur.ext_otg_active;
      tc_a         = item.typec_vbus & ~st_cur.typec_otg_active;
      redetect_due = 1'b0;
      host         = ~item.otg_id_high;

      unique case (item.action)
         ACT_VBUS: begin
            // Gate the sample by its source mask; magnetic samples are also dropped under ext otg
            case (item.trigger_source)
               SRC_MAG:   take = st_cur.mag_event_enabled & ~st_cur.ext_otg_active;
               SRC_TYPEC: take = st_cur.typec_event_enabled;
               SRC_TIMER: take = 1'b1;
               default:   take = 1'b0;
            endcase
            if (take && !(item.mag_vbus == st_cur.mag_input_valid &&
                          item.typec_vbus == st_cur.typec_input_valid)) begin
               // Type-C power arriving under ext otg: drop the boost
               if (st_cur.ext_otg_active && tc_a) begin
                  res.boost_write           = 1'b1;
                  res.boost_on              = 1'b0;
                  res.recheck_otg           = 1'b1;
                  st_next.ext_otg_seen      = 1'b0;
                  st_next.mag_event_enabled = 1'b1;
               end
               redetect_due = st_cur.mag_input_valid & st_cur.typec_input_valid &
                              (ext_a ^ tc_a);
               res.current_limit_ma = cfg.normal_current_ma;
               if (!redetect_due && ext_a && tc_a &&
                   (st_cur.mag_input_valid != st_cur.typec_input_valid)) begin
                  res.current_limit_ma = cfg.double_input_current_ma;
               end
               st_next.mag_input_valid   = ext_a;
               st_next.typec_input_valid = tc_a;
               // Double-to-single transition
               if (redetect_due) begin
                  res.force_recharge = ext_a & ~tc_a;
                  if (!st_cur.ext_otg_active && !ext_a) begin
                     st_next.data_switch_level = 1'b0;
                     res.rerun_detect          = 1'b1;
                  end
               end
               res.current_write = 1'b1;
               res.notify        = 1'b1;
            end
         end
         ACT_OTG: begin
            if ((host != st_cur.ext_otg_seen) ||
                (!st_cur.ext_otg_seen && st_cur.ext_otg_active)) begin
               if (!st_cur.typec_otg_active && !item.host_otg_present) begin
                  if (host) begin
                     st_next.mag_event_enabled = 1'b0;
                     st_next.mag_input_valid   = 1'b0;
                  end else begin
                     st_next.mag_event_enabled = 1'b1;
                  end
                  st_next.data_switch_level = host;
                  st_next.ext_otg_active    = host;
                  res.boost_write           = 1'b1;
                  res.boost_on              = host;
                  res.notify                = 1'b1;
               end
               st_next.ext_otg_seen = host;
            end
         end
         ACT_TCOTG: begin
            res.notify = 1'b1;
            if (st_cur.ext_otg_active) begin
               res.refused = 1'b1;
            end else begin
               if (item.enable) begin
                  st_next.typec_event_enabled = 1'b0;
                  st_next.data_switch_level   = 1'b0;
                  st_next.typec_input_valid   = 1'b0;
               end else begin
                  st_next.typec_event_enabled = 1'b1;
               end
               st_next.typec_otg_active = item.enable;
            end
         end
         ACT_ROUTE: begin
            if (item.enable && (st_cur.ext_otg_active || st_cur.typec_otg_active ||
                                st_cur.typec_input_valid)) begin
               res.refused = 1'b1;
            end else begin
               st_next.data_switch_level = item.enable;
               st_next.mag_data_routed   = item.enable;
            end
         end
         default: st_next = st_cur;
      endcase

      // Mode and data switch as they stand after the event
      if (st_next.ext_otg_active)
         res.mode = MODE_EXT_OTG;
      else if (st_next.typec_otg_active)
         res.mode = MODE_TC_OTG;
      else if (st_next.mag_input_valid && st_next.typec_input_valid)
         res.mode = MODE_BOTH_CHG;
      else if (st_next.mag_input_valid)
         res.mode = MODE_MAG_CHG;
      else if (st_next.typec_input_valid)
         res.mode = MODE_TC_CHG;
      else
         res.mode = MODE_IDLE;
      res.data_switch = st_next.data_switch_level;
   end

endmodule

### rtl/core/dual_input_charge_arbiter_core.sv
// Dual-input charge arbiter, top level: input register, event logic, result register.
// Two stages: a beat goes from the input register to the result register, then rsp_tdata.
// Throughput: one beat per cycle while rsp_tready does not stall the result register; the
// arbiter state updates as a beat leaves the input register, so the next beat sees it in the following cycle.
// Reset (synchronous, active high) restores the power-up state and current limits.
// Depends on dica_pkg, dica_csr_regs, dica_arb_step and assert_macros.svh.
`include "assert_macros.svh"
module dual_input_charge_arbiter_core (
   input  logic                           clock,
   input  logic                           reset,
   // Input events
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [1:0] trigger_source, [2] mag_vbus, [3] typec_vbus, [4] otg_id_high,
   // [5] host_otg_present, [6] enable, [7] zero
   input  logic [7:0]                     req_tdata,
   // [1:0] action
   input  logic [1:0]                     req_tuser,
   // Results
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [2:0] mode, [3] data_switch, [4] boost_write, [5] boost_on, [6] current_write,
   // [18:7] current_limit_ma, [19] force_recharge, [20] rerun_detect,
   // [21] recheck_otg, [22] notify, [23] refused
   output logic [23:0]                    rsp_tdata,
   // Configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dica_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dica_pkg::CUR_W-1:0]     csr_data
);
   import dica_pkg::*;

   cfg_type    cfg;
   item_type   req_item;
   item_type   in_item_ff;
   logic       in_vld_ff;
   state_type  st_ff;
   state_type  st_in;
   result_type step_res;
   result_type out_res_ff;
   logic       out_vld_ff;
   logic       fire;

   dica_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dica_arb_step u_step (
      .st_cur  (st_ff),
      .item    (in_item_ff),
      .cfg     (cfg),
      .st_next (st_in),
      .res     (step_res)
   );

   // Unpack the request beat
   assign req_item.action           = action_type'(req_tuser);
   assign req_item.trigger_source   = req_tdata[1:0];
   assign req_item.mag_vbus         = req_tdata[2];
   assign req_item.typec_vbus       = req_tdata[3];
   assign req_item.otg_id_high      = req_tdata[4];
   assign req_item.host_otg_present = req_tdata[5];
   assign req_item.enable           = req_tdata[6];

   // Advance when the result register is free or being drained
   assign fire       = in_vld_ff & (~out_vld_ff | rsp_tready);
   assign req_tready = ~in_vld_ff | fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_item;
      end
   end

   // Commit the arbiter state with each evaluated beat
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= STATE_RST;
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (fire) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_res_ff <= step_res;
      end
   end

   // Pack the result beat
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_res_ff.refused,
                        out_res_ff.notify,
                        out_res_ff.recheck_otg,
                        out_res_ff.rerun_detect,
                        out_res_ff.force_recharge,
                        out_res_ff.current_limit_ma,
                        out_res_ff.current_write,
                        out_res_ff.boost_on,
                        out_res_ff.boost_write,
                        out_res_ff.data_switch,
                        out_res_ff.mode};

   // The two otg paths never run together
   `ASSERT_SYNC(a_otg_exclusive, clock, reset, !(st_ff.ext_otg_active && st_ff.typec_otg_active))
   // Ext otg keeps the magnetic input marked absent
   `ASSERT_SYNC(a_ext_otg_no_mag, clock, reset, st_ff.ext_otg_active |-> !st_ff.mag_input_valid)
   // Type-C otg keeps the Type-C input marked absent
   `ASSERT_SYNC(a_tc_otg_no_tc, clock, reset, st_ff.typec_otg_active |-> !st_ff.typec_input_valid)
   // An evaluated beat always lands in the result register
   `ASSERT_SYNC(a_fire_loads, clock, reset, fire |=> out_vld_ff)
   // A current update is always reported to software
   `ASSERT_SYNC(a_cur_notify, clock, reset, (out_vld_ff && out_res_ff.current_write) |-> out_res_ff.notify)

endmodule
